[rtl/sdfcab_pkg.sv]
// ----------------------------------------------------------------------------
// sdfcab_pkg
// Shared constants and types for the distance-field coverage and alpha blend
// unit: register map, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package sdfcab_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int SPREAD_BITS    = 16;
   localparam int TEXT_BITS      = 8;
   localparam int NUM_CHANNELS   = 3;
   localparam int COVERAGE_BITS  = 17;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SPREAD     = 2'd0,
      CSR_TEXT_RED   = 2'd1,
      CSR_TEXT_GREEN = 2'd2,
      CSR_TEXT_BLUE  = 2'd3
   } csr_index_type;

   localparam logic [SPREAD_BITS-1:0] SPREAD_RESET = 16'd1024;
   localparam logic [SPREAD_BITS-1:0] SPREAD_ONE   = 16'd256;
   localparam logic [TEXT_BITS-1:0]   TEXT_RESET   = 8'd10;

   // Q0.16 constants.
   localparam logic [COVERAGE_BITS-1:0] Q16_ONE   = 17'd65536;
   localparam logic [COVERAGE_BITS-1:0] COVER_MIN = 17'd65;
   // Three in Q0.16, the constant of the (3 - 2t) factor of smoothstep.
   localparam logic [17:0] SMOOTH_THREE = 18'd196608;

endpackage

[rtl/sdfcab_ramp.sv]
// ----------------------------------------------------------------------------
// sdfcab_ramp
// Four-stage pipeline from the four distance samples to the clamped edge ramp
// value t in Q0.16: sample sum, spread multiply, reciprocal divide, and an
// exact remainder correction with clamping.
// ----------------------------------------------------------------------------
module sdfcab_ramp #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [sdfcab_pkg::SPREAD_BITS-1:0]          spread,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [3:0][CHANNEL_BITS-1:0]                samples,
   input  logic                                        beyond_edge,
   input  logic [sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] dest,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic [sdfcab_pkg::COVERAGE_BITS-1:0]        ramp,
   output logic                                        out_beyond_edge,
   output logic [sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] out_dest
);

   localparam int STAGES = 4;
   localparam int M      = (1 << CHANNEL_BITS) - 1;
   localparam int SUM_W  = CHANNEL_BITS + 2;
   localparam int D_W    = CHANNEL_BITS + 3;
   localparam int Z_W    = CHANNEL_BITS + 20;
   localparam int ZC_W   = CHANNEL_BITS + 10;
   localparam int QP_W   = ZC_W + 17;
   localparam int RW     = CHANNEL_BITS + 17;

   localparam logic signed [D_W-1:0] TWO_M     = D_W'(2 * M);
   localparam logic signed [Z_W-1:0] RAMP_OFS  = Z_W'(512 * M);
   localparam logic signed [Z_W-1:0] SAT_LIMIT = Z_W'(1024 * M);
   localparam logic [47:0] RECIP_WIDE = (48'd1 << (CHANNEL_BITS + 16)) / 48'(M);
   localparam logic [16:0] RECIP      = RECIP_WIDE[16:0];
   localparam logic [RW-1:0] M_RW     = RW'(M);

   // Stage handshake: a stage moves on when it is empty or the next one moves.
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = ~vld_ff[STAGES-1] | out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = ~vld_ff[i] | adv[i+1];
      end
      vld_in = {vld_ff[STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];

   // Side payload that rides along every stage.
   logic [STAGES-1:0] edge_ff;
   logic [STAGES-1:0][sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] dest_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         edge_ff[0] <= beyond_edge;
         dest_ff[0] <= dest;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (adv[i]) begin
            edge_ff[i] <= edge_ff[i-1];
            dest_ff[i] <= dest_ff[i-1];
         end
      end
   end

   // Stage 1: sum of the four samples.
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] sum_ff;

   assign sum_in = SUM_W'(samples[0]) + SUM_W'(samples[1])
                 + SUM_W'(samples[2]) + SUM_W'(samples[3]);

   // Stage 2: Z = (S - 2M) * P + 512M, so that t = floor(64Z / M).
   logic [sdfcab_pkg::SPREAD_BITS-1:0] p_val;
   logic signed [D_W-1:0]              d_val;
   logic signed [16:0]                 p_s;
   logic signed [Z_W-1:0]              z_in;
   logic signed [Z_W-1:0]              z_ff;

   always_comb begin
      p_val = (spread < sdfcab_pkg::SPREAD_ONE) ? sdfcab_pkg::SPREAD_ONE : spread;
      d_val = signed'({1'b0, sum_ff}) - TWO_M;
      p_s   = signed'({1'b0, p_val});
      z_in  = d_val * p_s + RAMP_OFS;
   end

   // Stage 3: clamp flags and the reciprocal product.
   logic            neg_in;
   logic            sat_in;
   logic [ZC_W-1:0] zc_in;
   logic [QP_W-1:0] qp_in;
   logic            neg_ff;
   logic            sat_ff;
   logic [ZC_W-1:0] zc_ff;
   logic [QP_W-1:0] qp_ff;

   always_comb begin
      neg_in = z_ff[Z_W-1] | (z_ff == '0);
      sat_in = (z_ff >= SAT_LIMIT);
      zc_in  = z_ff[ZC_W-1:0];
      qp_in  = QP_W'(zc_in) * QP_W'(RECIP);
   end

   // Stage 4: the estimate is low by at most one; the remainder fixes it.
   logic [15:0]                        q0;
   logic [RW-1:0]                      rem;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0] q_fix;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0] t_in;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0] t_ff;

   always_comb begin
      q0    = qp_ff[ZC_W+15:ZC_W];
      rem   = RW'({zc_ff, 6'b0}) - RW'({q0, {CHANNEL_BITS{1'b0}}}) + RW'(q0);
      q_fix = 17'(q0) + 17'(rem >= M_RW);
      if (neg_ff) begin
         t_in = '0;
      end else if (sat_ff) begin
         t_in = sdfcab_pkg::Q16_ONE;
      end else begin
         t_in = q_fix;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sum_ff <= sum_in;
      end
      if (adv[1]) begin
         z_ff <= z_in;
      end
      if (adv[2]) begin
         neg_ff <= neg_in;
         sat_ff <= sat_in;
         zc_ff  <= zc_in;
         qp_ff  <= qp_in;
      end
      if (adv[3]) begin
         t_ff <= t_in;
      end
   end

   assign ramp            = t_ff;
   assign out_beyond_edge = edge_ff[STAGES-1];
   assign out_dest        = dest_ff[STAGES-1];

endmodule

[rtl/sdfcab_smooth.sv]
// ----------------------------------------------------------------------------
// sdfcab_smooth
// Three-stage smoothstep t*t*(3-2t) in Q0.16 and the blend decision. The
// 33-bit square is multiplied in two halves so no multiplier exceeds 17x18.
// ----------------------------------------------------------------------------
module sdfcab_smooth #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [sdfcab_pkg::COVERAGE_BITS-1:0]        ramp,
   input  logic                                        beyond_edge,
   input  logic [sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] dest,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic [sdfcab_pkg::COVERAGE_BITS-1:0]        coverage,
   output logic                                        blended,
   output logic [sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] out_dest
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = ~vld_ff[STAGES-1] | out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = ~vld_ff[i] | adv[i+1];
      end
      vld_in = {vld_ff[STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];

   logic [STAGES-2:0] edge_ff;
   logic [STAGES-1:0][sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] dest_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dest_ff[0] <= dest;
         edge_ff[0] <= beyond_edge;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (adv[i]) begin
            dest_ff[i] <= dest_ff[i-1];
         end
      end
      for (int i = 1; i < STAGES - 1; i++) begin
         if (adv[i]) begin
            edge_ff[i] <= edge_ff[i-1];
         end
      end
   end

   // Stage 1: square and the (3 - 2t) factor.
   logic [32:0] sq_in;
   logic [17:0] fac_in;
   logic [32:0] sq_ff;
   logic [17:0] fac_ff;

   always_comb begin
      sq_in  = 33'(34'(ramp) * 34'(ramp));
      fac_in = sdfcab_pkg::SMOOTH_THREE - {ramp, 1'b0};
   end

   // Stage 2: split product.
   logic [34:0] ph_in;
   logic [33:0] pl_in;
   logic [34:0] ph_ff;
   logic [33:0] pl_ff;

   always_comb begin
      ph_in = 35'(sq_ff[32:16]) * 35'(fac_ff);
      pl_in = 34'(sq_ff[15:0]) * 34'(fac_ff);
   end

   // Stage 3: recombine, take the top bits, decide whether to blend.
   logic [50:0]                          total;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0] cov_in;
   logic                                 blend_in;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0] cov_ff;
   logic                                 blend_ff;

   always_comb begin
      total    = {ph_ff, 16'b0} + 51'(pl_ff);
      // An off-glyph pixel reports no coverage at all.
      cov_in   = edge_ff[STAGES-2] ? '0 : total[48:32];
      blend_in = (cov_in > sdfcab_pkg::COVER_MIN);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sq_ff  <= sq_in;
         fac_ff <= fac_in;
      end
      if (adv[1]) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
      if (adv[2]) begin
         cov_ff   <= cov_in;
         blend_ff <= blend_in;
      end
   end

   assign coverage = cov_ff;
   assign blended  = blend_ff;
   assign out_dest = dest_ff[STAGES-1];

endmodule

[rtl/sdfcab_blend.sv]
// ----------------------------------------------------------------------------
// sdfcab_blend
// Two-stage alpha blend of the text color over the destination, one lane per
// channel: dest + (text - dest) * a, then the output register.
// ----------------------------------------------------------------------------
module sdfcab_blend #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] text,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [sdfcab_pkg::COVERAGE_BITS-1:0]        coverage,
   input  logic                                        blended,
   input  logic [sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] dest,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic [sdfcab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] out_pixel,
   output logic                                        out_blended,
   output logic [sdfcab_pkg::COVERAGE_BITS-1:0]        out_coverage
);

   localparam int STAGES = 2;
   localparam int NCH    = sdfcab_pkg::NUM_CHANNELS;
   localparam int PW     = CHANNEL_BITS + 19;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = ~vld_ff[STAGES-1] | out_ready;
      adv[0]        = ~vld_ff[0] | adv[1];
      vld_in        = {vld_ff[0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];

   // Stage 1: signed difference times coverage, per channel.
   logic signed [CHANNEL_BITS:0]  diff [NCH];
   logic signed [17:0]            cov_s;
   logic signed [NCH-1:0][PW-1:0] prod_in;
   logic signed [NCH-1:0][PW-1:0] prod_ff;
   logic [NCH-1:0][CHANNEL_BITS-1:0] dest_ff;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0] cov_ff;
   logic                                 blend_ff;

   always_comb begin
      cov_s = signed'({1'b0, coverage});
      for (int c = 0; c < NCH; c++) begin
         diff[c]    = signed'({1'b0, text[c]}) - signed'({1'b0, dest[c]});
         prod_in[c] = PW'(diff[c] * cov_s);
      end
   end

   // Stage 2: add the destination back and drop the fraction.
   logic signed [PW-1:0]             mix_sum [NCH];
   logic [NCH-1:0][CHANNEL_BITS-1:0] pix_in;
   logic [NCH-1:0][CHANNEL_BITS-1:0] pix_ff;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0] cov_out_ff;
   logic                                 blend_out_ff;

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         mix_sum[c] = signed'({3'b0, dest_ff[c], 16'b0}) + signed'(prod_ff[c]);
         pix_in[c]  = blend_ff ? mix_sum[c][CHANNEL_BITS+15:16] : dest_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod_ff  <= prod_in;
         dest_ff  <= dest;
         cov_ff   <= coverage;
         blend_ff <= blended;
      end
      if (adv[1]) begin
         pix_ff       <= pix_in;
         cov_out_ff   <= cov_ff;
         blend_out_ff <= blend_ff;
      end
   end

   assign out_pixel    = pix_ff;
   assign out_blended  = blend_out_ff;
   assign out_coverage = cov_out_ff;

endmodule

[rtl/sdf_coverage_alpha_blend_unit.sv]
// ----------------------------------------------------------------------------
// sdf_coverage_alpha_blend_unit
// Signed-distance-field glyph coverage with smoothstep shaping and alpha blend
// of the text color over one destination pixel per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake         Carries
//  req_      in         valid / ready     four samples, edge flag, dest RGB
//  rsp_      out        valid / ready     out RGB, blended flag, coverage
//  csr_      in         write enable      spread, text red / green / blue
//
// One request per clock unless the response side stalls. The ramp stages
// (sum, spread multiply, reciprocal divide, remainder fix) feed smoothstep,
// then the blend and output register. Every stage has its own valid bit
// and moves on whenever the stage after it is free, so bubbles close up while
// the response side is stalled and no request is dropped or repeated.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module sdf_coverage_alpha_blend_unit #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [CHANNEL_BITS-1:0]                   req_sample_top_left,
   input  logic [CHANNEL_BITS-1:0]                   req_sample_top_right,
   input  logic [CHANNEL_BITS-1:0]                   req_sample_bottom_left,
   input  logic [CHANNEL_BITS-1:0]                   req_sample_bottom_right,
   input  logic                                      req_beyond_edge,
   input  logic [CHANNEL_BITS-1:0]                   req_dest_red,
   input  logic [CHANNEL_BITS-1:0]                   req_dest_green,
   input  logic [CHANNEL_BITS-1:0]                   req_dest_blue,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [CHANNEL_BITS-1:0]                   rsp_out_red,
   output logic [CHANNEL_BITS-1:0]                   rsp_out_green,
   output logic [CHANNEL_BITS-1:0]                   rsp_out_blue,
   output logic                                      rsp_blended,
   output logic [sdfcab_pkg::COVERAGE_BITS-1:0]      rsp_coverage,
   input  logic                                      csr_write,
   input  logic [sdfcab_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sdfcab_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   localparam int NCH = sdfcab_pkg::NUM_CHANNELS;

   // Configuration registers.
   logic [sdfcab_pkg::SPREAD_BITS-1:0]        spread_ff;
   logic [NCH-1:0][sdfcab_pkg::TEXT_BITS-1:0] text_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_ff <= sdfcab_pkg::SPREAD_RESET;
         text_ff   <= {NCH{sdfcab_pkg::TEXT_RESET}};
      end else if (csr_write) begin
         case (sdfcab_pkg::csr_index_type'(csr_index))
            sdfcab_pkg::CSR_SPREAD: begin
               spread_ff <= csr_data;
            end
            sdfcab_pkg::CSR_TEXT_RED: begin
               text_ff[0] <= csr_data[sdfcab_pkg::TEXT_BITS-1:0];
            end
            sdfcab_pkg::CSR_TEXT_GREEN: begin
               text_ff[1] <= csr_data[sdfcab_pkg::TEXT_BITS-1:0];
            end
            sdfcab_pkg::CSR_TEXT_BLUE: begin
               text_ff[2] <= csr_data[sdfcab_pkg::TEXT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The color registers are fitted to the channel width.
   logic [NCH-1:0][CHANNEL_BITS-1:0] text_ch;

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         text_ch[c] = CHANNEL_BITS'(text_ff[c]);
      end
   end

   logic [3:0][CHANNEL_BITS-1:0]   samples;
   logic [NCH-1:0][CHANNEL_BITS-1:0] req_dest;

   assign samples  = {req_sample_bottom_right, req_sample_bottom_left,
                      req_sample_top_right, req_sample_top_left};
   assign req_dest = {req_dest_blue, req_dest_green, req_dest_red};

   // Ramp to smoothstep.
   logic                                  ramp_valid;
   logic                                  ramp_ready;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0]  ramp_t;
   logic                                  ramp_edge;
   logic [NCH-1:0][CHANNEL_BITS-1:0]      ramp_dest;

   sdfcab_ramp #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_ramp (
      .clock          (clock),
      .reset          (reset),
      .spread         (spread_ff),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .samples        (samples),
      .beyond_edge    (req_beyond_edge),
      .dest           (req_dest),
      .out_valid      (ramp_valid),
      .out_ready      (ramp_ready),
      .ramp           (ramp_t),
      .out_beyond_edge(ramp_edge),
      .out_dest       (ramp_dest)
   );

   // Smoothstep to blend.
   logic                                  cov_valid;
   logic                                  cov_ready;
   logic [sdfcab_pkg::COVERAGE_BITS-1:0]  cov_val;
   logic                                  cov_blend;
   logic [NCH-1:0][CHANNEL_BITS-1:0]      cov_dest;

   sdfcab_smooth #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_smooth (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (ramp_valid),
      .in_ready   (ramp_ready),
      .ramp       (ramp_t),
      .beyond_edge(ramp_edge),
      .dest       (ramp_dest),
      .out_valid  (cov_valid),
      .out_ready  (cov_ready),
      .coverage   (cov_val),
      .blended    (cov_blend),
      .out_dest   (cov_dest)
   );

   logic [NCH-1:0][CHANNEL_BITS-1:0] rsp_pixel;

   sdfcab_blend #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_blend (
      .clock       (clock),
      .reset       (reset),
      .text        (text_ch),
      .in_valid    (cov_valid),
      .in_ready    (cov_ready),
      .coverage    (cov_val),
      .blended     (cov_blend),
      .dest        (cov_dest),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_pixel   (rsp_pixel),
      .out_blended (rsp_blended),
      .out_coverage(rsp_coverage)
   );

   assign rsp_out_red   = rsp_pixel[0];
   assign rsp_out_green = rsp_pixel[1];
   assign rsp_out_blue  = rsp_pixel[2];

endmodule
